[hw/rtl/rational_number_alu_core_assert.svh]
// Assertion macros used by the rational ALU core.
`ifndef RATIONAL_NUMBER_ALU_CORE_ASSERT_SVH
`define RATIONAL_NUMBER_ALU_CORE_ASSERT_SVH

// Plain property checked on every rising clock edge outside of reset.
`define RNA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define RNA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rna_pkg.sv]
`default_nettype none
package rna_pkg;
	localparam int WordBits = 32;
	localparam int DenBits  = WordBits - 1;
	localparam int WideBits = 2 * WordBits;
	localparam int CntBits  = 7;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_CMP = 3'd5
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIVZERO  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_PREP,
		S_LOAD,
		S_GCD,
		S_GCD_STEP,
		S_DIVN,
		S_DIVD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [WideBits-1:0] dividend;
		logic [WideBits-1:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

[hw/rtl/rna_if.sv]
`default_nettype none
interface rna_in_if (input wire logic clk);
	import rna_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 command;
	logic signed [WordBits-1:0] a_num;
	logic [DenBits-1:0]         a_den;
	logic signed [WordBits-1:0] b_num;
	logic [DenBits-1:0]         b_den;
	modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_out_if (input wire logic clk);
	import rna_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [WordBits-1:0] res_num;
	logic [DenBits-1:0]         res_den;
	logic                       less;
	logic                       greater;
	logic                       equal;
	logic [1:0]                 status;
	modport source (output valid, res_num, res_den, less, greater, equal, status, input ready);
	modport sink (input valid, res_num, res_den, less, greater, equal, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/rational_number_alu_core.sv]
// Channel  Dir  Payload
// in       in   command, a_num, a_den, b_num, b_den
// out      out  res_num, res_den, less, greater, equal, status
// One word is taken at a time; ready stays low until its result is taken.
// Cross products come from S_MUL1, S_MUL2 and S_MUL3 on a shared 33x33 multiplier, then
// S_PREP and S_LOAD set up. Each gcd step is an issue state (S_GCD), a restoring divide
// and a wait for its done (S_GCD_STEP); the two final divisions (S_DIVN, S_DIVD) follow
// before a result is offered, and compare, zero and error cases go from S_LOAD to S_DONE.
// Reset clears the state register and the divider control; a stalled result holds until taken.
`default_nettype none
`include "rational_number_alu_core_assert.svh"
module rational_number_alu_core (
	input wire logic   clk,
	input wire logic   arst_n,
	rna_in_if.sink     in,
	rna_out_if.source  out
);
	import rna_pkg::*;

	state_t state_q, state_d;
	logic [2:0]                  cmd_q;
	logic signed [WordBits-1:0]  an_q, bn_q;
	logic signed [WordBits:0]    ad_q, bd_q;
	logic signed [WideBits+1:0]  p0_q, p1_q, p2_q;
	logic signed [WideBits+1:0]  num_q, den_q;
	logic [WideBits-1:0]         x_q, y_q, n_q, d_q;
	logic                        neg_q;
	logic signed [WordBits:0]    ma, mb;
	logic signed [WideBits+1:0]  prod;
	logic [1:0]                  msel;
	logic                        dstart;
	div_req_t                    dreq;
	logic                        dbusy, ddone;
	logic [WideBits-1:0]         dquot, drem;
	logic [WideBits-1:0]         lim;
	logic                        ov_valid_q;

	assign lim = WideBits'((64'd1 << (WordBits - 1)) - 64'd1);

	always_comb begin
		case (msel)
			2'd0: begin ma = {an_q[WordBits-1], an_q}; mb = bd_q; end
			2'd1: begin ma = {bn_q[WordBits-1], bn_q}; mb = ad_q; end
			2'd2: begin ma = ad_q; mb = bd_q; end
			default: begin ma = {an_q[WordBits-1], an_q}; mb = {bn_q[WordBits-1], bn_q}; end
		endcase
		prod = (WideBits+2)'(ma * mb);
	end

	rna_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .req(dreq),
		.busy(dbusy), .done(ddone), .quot(dquot), .rem(drem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		msel    = 2'd0;
		dstart  = 1'b0;
		dreq.dividend = x_q;
		dreq.divisor  = y_q;
		in.ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: if (in.valid) state_d = S_MUL1;
			S_MUL1: begin msel = 2'd0; state_d = S_MUL2; end
			S_MUL2: begin
				msel = (cmd_q == CMD_MUL) ? 2'd3 : 2'd1;
				state_d = S_MUL3;
			end
			S_MUL3: begin msel = 2'd2; state_d = S_PREP; end
			S_PREP: state_d = S_LOAD;
			S_LOAD: state_d = (ov_valid_q && num_q != '0) ? S_GCD : S_DONE;
			S_GCD: begin
				dstart = 1'b1;
				if (y_q == '0) begin
					dreq.dividend = n_q;
					dreq.divisor  = x_q;
					state_d = S_DIVN;
				end else begin
					state_d = S_GCD_STEP;
				end
			end
			S_GCD_STEP: if (ddone) state_d = S_GCD;
			S_DIVN: if (ddone) begin
				dreq.dividend = d_q;
				dreq.divisor  = x_q;
				dstart  = 1'b1;
				state_d = S_DIVD;
			end
			S_DIVD: if (ddone) state_d = S_DONE;
			S_DONE: if (out.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in.valid) begin
				cmd_q <= in.command;
				an_q  <= in.a_num;
				bn_q  <= in.b_num;
				ad_q  <= {2'b00, in.a_den};
				bd_q  <= {2'b00, in.b_den};
				out.less <= 1'b0; out.greater <= 1'b0; out.equal <= 1'b0;
				out.res_num <= '0; out.res_den <= DenBits'(1);
				out.status <= ST_OK;
			end
			S_MUL1: p0_q <= prod;
			S_MUL2: p1_q <= prod;
			S_MUL3: p2_q <= prod;
			S_PREP: begin
				if (cmd_q > 3'(CMD_CMP)) begin
					ov_valid_q <= 1'b0;
				end else if (ad_q == '0 || bd_q == '0) begin
					ov_valid_q <= 1'b0;
					out.status <= ST_DIVZERO;
				end else if (cmd_q == CMD_CMP) begin
					ov_valid_q  <= 1'b0;
					out.less    <= p0_q < p1_q;
					out.greater <= p0_q > p1_q;
					out.equal   <= p0_q == p1_q;
				end else if (cmd_q == CMD_DIV && bn_q == '0) begin
					ov_valid_q <= 1'b0;
					out.status <= ST_DIVZERO;
				end else begin
					case (cmd_q)
						CMD_ADD: begin num_q <= p0_q + p1_q; den_q <= p2_q; end
						CMD_SUB: begin num_q <= p0_q - p1_q; den_q <= p2_q; end
						CMD_MUL: begin num_q <= p1_q; den_q <= p2_q; end
						CMD_DIV: begin num_q <= p0_q; den_q <= p1_q; end
						default: begin
							num_q <= -(WideBits+2)'(an_q);
							den_q <= (WideBits+2)'(ad_q);
						end
					endcase
					ov_valid_q <= 1'b1;
				end
			end
			S_LOAD: if (ov_valid_q) begin
				neg_q <= (num_q < 0) != (den_q < 0);
				n_q   <= (num_q < 0) ? WideBits'(-num_q) : WideBits'(num_q);
				d_q   <= (den_q < 0) ? WideBits'(-den_q) : WideBits'(den_q);
				x_q   <= (num_q < 0) ? WideBits'(-num_q) : WideBits'(num_q);
				y_q   <= (den_q < 0) ? WideBits'(-den_q) : WideBits'(den_q);
			end
			S_GCD: if (y_q != '0) x_q <= y_q;
			S_GCD_STEP: if (ddone) y_q <= drem;
			S_DIVN: if (ddone) n_q <= dquot;
			S_DIVD: if (ddone) begin
				if (n_q > lim || dquot > lim) begin
					out.status <= ST_OVERFLOW;
				end else begin
					out.res_num <= neg_q ? -WordBits'(n_q) : WordBits'(n_q);
					out.res_den <= DenBits'(dquot);
				end
			end
			default: ;
		endcase
	end

	assign out.valid = (state_q == S_DONE);

	`RNA_ASSERT(a_ready_idle, clk, arst_n, in.ready == (state_q == S_IDLE), "ready outside idle")
	`RNA_ASSERT_NEXT(a_hold, clk, arst_n, out.valid && !out.ready, out.valid, "result dropped")
	`RNA_ASSERT(a_excl, clk, arst_n, !(out.less && out.greater) || !out.valid, "flags clash")
	`RNA_ASSERT(a_div_start, clk, arst_n, !(dstart && dbusy), "divider restarted while busy")
endmodule
`default_nettype wire

[hw/rtl/rna_divider.sv]
`default_nettype none
module rna_divider (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire rna_pkg::div_req_t        req,
	output logic                          busy,
	output logic                          done,
	output logic [rna_pkg::WideBits-1:0]  quot,
	output logic [rna_pkg::WideBits-1:0]  rem
);
	import rna_pkg::*;

	logic [WideBits-1:0] div_q;
	logic [WideBits:0]   trial;
	logic [CntBits-1:0]  cnt_q;
	logic                busy_q;
	logic                done_q;

	assign trial = {rem, quot[WideBits-1]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntBits'(WideBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot  <= req.dividend;
			rem   <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[WideBits]) begin
				rem  <= trial[WideBits-1:0];
				quot <= {quot[WideBits-2:0], 1'b1};
			end else begin
				rem  <= {rem[WideBits-2:0], quot[WideBits-1]};
				quot <= {quot[WideBits-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import rna_pkg::*;

	localparam longint CycleLimit = 40_000_000;
	localparam longint NumMax = 64'sd2147483647;

	typedef struct packed {
		logic signed [WordBits-1:0] num;
		logic [DenBits-1:0]         den;
		logic                       less;
		logic                       greater;
		logic                       equal;
		logic [1:0]                 status;
	} fraction_result_t;

	logic clk;
	logic arst_n;
	rna_in_if in_if (clk);
	rna_out_if out_if (clk);

	rational_number_alu_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if),
		.out(out_if)
	);

	fraction_result_t pending_results[$];
	bit failed;
	longint cycle_count;
	int burst_left;
	int hold_off_cycles;
	int stall_mode;
	int stall_mode_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void reduce_fraction(longint n, longint d, inout fraction_result_t r);
		bit neg;
		longint unsigned un, ud, x, y, t;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		if (un == 0)
			return;
		x = un;
		y = ud;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		un = un / x;
		ud = ud / x;
		if (un > NumMax || ud > NumMax) begin
			r.status = ST_OVERFLOW;
			return;
		end
		r.num = neg ? -un[31:0] : un[31:0];
		r.den = ud[30:0];
	endfunction

	function automatic fraction_result_t predict_fraction(logic [2:0] cmd,
			logic signed [31:0] an_in, logic [30:0] ad_in,
			logic signed [31:0] bn_in, logic [30:0] bd_in);
		fraction_result_t r;
		longint an, ad, bn, bd;
		an = an_in;
		ad = {33'd0, ad_in};
		bn = bn_in;
		bd = {33'd0, bd_in};
		r = '0;
		r.den = 1;
		r.status = ST_OK;
		if (cmd > CMD_CMP)
			return r;
		if (ad == 0 || bd == 0) begin
			r.status = ST_DIVZERO;
			return r;
		end
		case (cmd)
			CMD_ADD: reduce_fraction(an * bd + bn * ad, ad * bd, r);
			CMD_SUB: reduce_fraction(an * bd - bn * ad, ad * bd, r);
			CMD_MUL: reduce_fraction(an * bn, ad * bd, r);
			CMD_DIV: begin
				if (bn == 0)
					r.status = ST_DIVZERO;
				else
					reduce_fraction(an * bd, ad * bn, r);
			end
			CMD_NEG: reduce_fraction(-an, ad, r);
			default: begin
				r.less = (an * bd) < (bn * ad);
				r.greater = (an * bd) > (bn * ad);
				r.equal = (an * bd) == (bn * ad);
			end
		endcase
		return r;
	endfunction

	task automatic send_word(logic [2:0] cmd, logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_if.valid <= 1'b1;
		in_if.command <= cmd;
		in_if.a_num <= an;
		in_if.a_den <= ad;
		in_if.b_num <= bn;
		in_if.b_den <= bd;
		do @(posedge clk); while (!in_if.ready);
		pending_results.push_back(predict_fraction(cmd, an, ad, bn, bd));
		burst_left--;
	endtask

	task automatic drain_results();
		in_if.valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic signed [31:0] random_num();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $signed($urandom_range(0, 510)) - 255;
			5, 6, 7: return $signed($urandom_range(0, 131070)) - 65535;
			8: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh80000001;
					3: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [30:0] random_den();
		case ($urandom_range(0, 49))
			0: return 0;
			1: return 31'h7fffffff;
			2, 3, 4, 5: return 31'($urandom);
			6, 7, 8, 9, 10, 11, 12: return 31'($urandom_range(1, 65535));
			default: return 31'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [2:0] random_command();
		if ($urandom_range(0, 39) == 0)
			return 3'($urandom_range(6, 7));
		return 3'($urandom_range(CMD_ADD, CMD_CMP));
	endfunction

	task automatic test_extremes();
		send_word(CMD_ADD, 1, 2, 1, 3);
		send_word(CMD_SUB, 3, 7, 6, 14);
		send_word(CMD_MUL, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
		send_word(CMD_MUL, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff);
		send_word(CMD_DIV, 32'sh7fffffff, 31'h7fffffff, 32'sh80000001, 1);
		send_word(CMD_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
		send_word(CMD_SUB, 32'sh80000000, 1, 32'sh80000000, 1);
		send_word(CMD_NEG, 32'sh7fffffff, 31'h7fffffff, 0, 1);
		send_word(CMD_CMP, 32'sh80000000, 1, 32'sh7fffffff, 31'h7fffffff);
		send_word(CMD_CMP, 32'sh7fffffff, 31'h7ffffffe, 32'sh7ffffffe, 31'h7ffffffd);
		send_word(CMD_ADD, -5, 6, 5, 6);
	endtask

	task automatic test_special_cases();
		send_word(CMD_DIV, 3, 4, 0, 9);
		send_word(CMD_ADD, 1, 0, 1, 1);
		send_word(CMD_CMP, 1, 1, 1, 0);
		send_word(CMD_NEG, 32'sh80000000, 1, 0, 1);
		send_word(CMD_NEG, 32'sh80000000, 2, 0, 1);
		send_word(CMD_CMP, 2, 4, 1, 2);
		send_word(CMD_CMP, -3, 9, 1, 3);
		send_word(CMD_MUL, 6, 8, 4, 10);
		send_word(3'd6, 7, 3, 2, 5);
		send_word(3'd7, -7, 0, 2, 0);
		send_word(CMD_DIV, -4, 6, -2, 3);
		drain_results();
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_word(random_command(), random_num(), random_den(), random_num(), random_den());
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 3000;
		repeat (6)
			send_word(random_command(), random_num(), random_den(), random_num(), random_den());
		drain_results();
		test_random(30);
		drain_results();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_mode <= 0;
			stall_mode_left <= 0;
		end else if (hold_off_cycles > 0) begin
			out_if.ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_mode_left <= $urandom_range(20, 400);
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			case (stall_mode)
				0: out_if.ready <= 1'b1;
				1: out_if.ready <= $urandom_range(0, 1);
				default: out_if.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		fraction_result_t got, want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got.num = out_if.res_num;
			got.den = out_if.res_den;
			got.less = out_if.less;
			got.greater = out_if.greater;
			got.equal = out_if.equal;
			got.status = out_if.status;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %p", $time, got);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (got.num !== want.num) begin
					$display("%0t res_num: expected %0d, actual %0d", $time, want.num, got.num);
					failed = 1'b1;
				end
				if (got.den !== want.den) begin
					$display("%0t res_den: expected %0d, actual %0d", $time, want.den, got.den);
					failed = 1'b1;
				end
				if (got.less !== want.less) begin
					$display("%0t less: expected %0b, actual %0b", $time, want.less, got.less);
					failed = 1'b1;
				end
				if (got.greater !== want.greater) begin
					$display("%0t greater: expected %0b, actual %0b", $time, want.greater,
						got.greater);
					failed = 1'b1;
				end
				if (got.equal !== want.equal) begin
					$display("%0t equal: expected %0b, actual %0b", $time, want.equal, got.equal);
					failed = 1'b1;
				end
				if (got.status !== want.status) begin
					$display("%0t status: expected %0d, actual %0d", $time, want.status,
						got.status);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAIL rational_number_alu_core");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		cycle_count = 0;
		burst_left = 0;
		hold_off_cycles = 0;
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.command <= CMD_ADD;
		in_if.a_num <= '0;
		in_if.a_den <= 1;
		in_if.b_num <= '0;
		in_if.b_den <= 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_special_cases();
		test_random(800);
		test_backpressure();
		test_random(900);
		drain_results();
		repeat (8000) @(posedge clk);
		if (failed || pending_results.size() != 0)
			$display("FAIL rational_number_alu_core");
		else
			$display("PASS rational_number_alu_core");
		$finish;
	end
endmodule
`default_nettype wire
